>>> rtl/acp_pkg.sv
// Shared types, codes and constants for the audio clip player.
// Used by every module of the block; depends on nothing.
`default_nettype none

package acp_pkg;

  // Default sizing handed to the top level parameters
  localparam int CLIP_COUNT_DEF   = 6;
  localparam int ADDRESS_BITS_DEF = 24;

  // Field widths
  localparam int NUM_BASE    = 6;
  localparam int BASE_W      = 24;
  localparam int OP_W        = 3;
  localparam int ID_W        = 3;
  localparam int WORD_W      = 16;
  localparam int DAC_W       = 12;
  localparam int VOL_W       = 5;
  localparam int SCALE_SHIFT = 4;

  // Configuration port
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_TICK     = 3'd0;
  localparam logic [OP_W-1:0] OP_OPEN     = 3'd1;
  localparam logic [OP_W-1:0] OP_CLOSE    = 3'd2;
  localparam logic [OP_W-1:0] OP_VOL_UP   = 3'd3;
  localparam logic [OP_W-1:0] OP_VOL_DOWN = 3'd4;

  // Special values
  localparam logic [WORD_W-1:0] END_WORD    = 16'hFFFF;
  localparam logic [VOL_W-1:0]  FULL_VOLUME = 5'd16;
  localparam logic [ID_W-1:0]   START_CLIP  = 3'd1;
  localparam logic [ID_W-1:0]   MUSIC_CLIP  = 3'd4;

  typedef logic [NUM_BASE-1:0][BASE_W-1:0] acp_bases_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   clip_id;
    logic [WORD_W-1:0] sample_word;
  } acp_item_t;

  typedef struct packed {
    logic              dac_write;
    logic [DAC_W-1:0]  dac_value;
    logic              playing;
    logic [BASE_W-1:0] read_address;
    logic [VOL_W-1:0]  volume_level;
  } acp_result_t;

endpackage

`default_nettype wire

>>> rtl/audio_clip_player_with_volume_core.sv
// Top level of the audio clip player: input register, result register, wiring.
// Depends on acp_pkg, acp_cfg and acp_engine.
//
// The player takes one event word per clock cycle while in_ready is high (tick,
// open, close, volume up, volume down) and returns one result word for each: DAC
// write strobe and value, playing flag, the flash byte address whose word the next
// tick must carry, and the volume. A word is captured in an input register; when
// the output register is free or being drained, its result is computed from the
// player state and loaded into the output register, which raises out_valid.
// Throughput is one word per cycle while out_ready is high. While a result waits
// to be taken the input register still takes one word, then in_ready stays low
// until the result leaves. The user must write clip base addresses through the
// APB port only while no word is in flight; the block itself does not enforce it.
`default_nettype none

module audio_clip_player_with_volume_core #(
  parameter int CLIP_COUNT   = acp_pkg::CLIP_COUNT_DEF,
  parameter int ADDRESS_BITS = acp_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Event words
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [acp_pkg::OP_W-1:0]      in_operation,
  input  wire logic [acp_pkg::ID_W-1:0]      in_clip_id,
  input  wire logic [acp_pkg::WORD_W-1:0]    in_sample_word,
  // Result words
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               out_dac_write,
  output logic      [acp_pkg::DAC_W-1:0]     out_dac_value,
  output logic                               out_playing,
  output logic      [acp_pkg::BASE_W-1:0]    out_read_address,
  output logic      [acp_pkg::VOL_W-1:0]     out_volume_level,
  // Configuration
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [acp_pkg::CFG_AW-1:0]    cfg_paddr,
  input  wire logic [acp_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic      [acp_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  acp_pkg::acp_bases_t   bases;
  acp_pkg::acp_item_t    item_r;
  acp_pkg::acp_result_t  result;
  acp_pkg::acp_result_t  result_r;
  logic                  item_valid_r;
  logic                  out_valid_r;
  logic                  step;
  logic                  in_take;

  acp_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .bases_o (bases)
  );

  acp_engine #(
    .CLIP_COUNT   (CLIP_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_i   (step),
    .item_i   (item_r),
    .bases_i  (bases),
    .result_o (result)
  );

  // Advance the held word when the result register is free or being drained
  assign step     = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || step;
  assign in_take  = in_valid && in_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_ready) begin
      item_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.operation   <= in_operation;
      item_r.clip_id     <= in_clip_id;
      item_r.sample_word <= in_sample_word;
    end
  end

  // Result register: load on step, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dac_write    = result_r.dac_write;
  assign out_dac_value    = result_r.dac_value;
  assign out_playing      = result_r.playing;
  assign out_read_address = result_r.read_address;
  assign out_volume_level = result_r.volume_level;

  // Volume never leaves its range
  a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r |-> (result_r.volume_level <= acp_pkg::FULL_VOLUME))
    else $error("volume above full scale");

  // A DAC write only happens while a clip keeps playing
  a_write_playing: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && result_r.dac_write) |-> result_r.playing)
    else $error("DAC write while stopped");

  // Without a write the DAC value is zero
  a_value_idle: assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !result_r.dac_write) |-> (result_r.dac_value == '0))
    else $error("DAC value without write");

  // An accepted word is held in the input register next cycle
  a_take_hold: assert property (@(posedge clk) disable iff (!rst_n)
      in_take |=> item_valid_r)
    else $error("accepted word lost");

endmodule

`default_nettype wire

>>> rtl/acp_cfg.sv
// APB-style register file holding the clip base addresses.
// Depends on acp_pkg.
`default_nettype none

module acp_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [acp_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [acp_pkg::CFG_DW-1:0]   pwdata,
  output logic      [acp_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready,
  output acp_pkg::acp_bases_t               bases_o
);

  localparam int IDX_W = acp_pkg::CFG_AW - 2;

  acp_pkg::acp_bases_t   bases_r;
  logic [IDX_W-1:0]      idx;
  logic                  wr_en;

  assign idx    = paddr[acp_pkg::CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign bases_o = bases_r;

  // Write the addressed base register during the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bases_r <= '0;
    end else if (wr_en && ({1'b0, idx} < (IDX_W+1)'(acp_pkg::NUM_BASE))) begin
      bases_r[idx] <= pwdata[acp_pkg::BASE_W-1:0];
    end
  end

  // Read back, zero beyond the register list
  always_comb begin
    prdata = '0;
    if ({1'b0, idx} < (IDX_W+1)'(acp_pkg::NUM_BASE)) begin
      prdata = acp_pkg::CFG_DW'(bases_r[idx]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/acp_engine.sv
// Player state and the per-word step: clip control, volume, sample scaling.
// Depends on acp_pkg; takes the base addresses from acp_cfg.
`default_nettype none

module acp_engine #(
  parameter int CLIP_COUNT   = acp_pkg::CLIP_COUNT_DEF,
  parameter int ADDRESS_BITS = acp_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step_i,
  input  acp_pkg::acp_item_t        item_i,
  input  acp_pkg::acp_bases_t       bases_i,
  output acp_pkg::acp_result_t      result_o
);

  localparam int ID_W   = acp_pkg::ID_W;
  localparam int VOL_W  = acp_pkg::VOL_W;
  localparam int PROD_W = acp_pkg::WORD_W + VOL_W;
  localparam int WIDE_W = (ADDRESS_BITS > acp_pkg::BASE_W) ? ADDRESS_BITS : acp_pkg::BASE_W;

  logic                    active_r, active_nxt;
  logic [ID_W-1:0]         clip_r, clip_nxt;
  logic [ADDRESS_BITS-1:0] offset_r, offset_nxt;
  logic [VOL_W-1:0]        volume_r, volume_nxt;
  logic                    music_r, music_nxt;

  logic                      dac_write;
  logic [PROD_W-1:0]         product;
  logic [acp_pkg::BASE_W-1:0] base_sel;
  logic [WIDE_W-1:0]         addr_sum;

  // Scale the sample by the current volume
  assign product = PROD_W'(item_i.sample_word) * PROD_W'(volume_r);

  // Next state for one word
  always_comb begin
    active_nxt = active_r;
    clip_nxt   = clip_r;
    offset_nxt = offset_r;
    volume_nxt = volume_r;
    music_nxt  = music_r;
    dac_write  = 1'b0;
    case (item_i.operation)
      acp_pkg::OP_TICK: begin
        if (active_r) begin
          if (item_i.sample_word == acp_pkg::END_WORD) begin
            // Start prompt with music on, or the music itself: loop music
            if ((clip_r == acp_pkg::START_CLIP && music_r) ||
                clip_r == acp_pkg::MUSIC_CLIP) begin
              clip_nxt   = acp_pkg::MUSIC_CLIP;
              offset_nxt = '0;
            end else begin
              active_nxt = 1'b0;
            end
          end else begin
            dac_write  = 1'b1;
            offset_nxt = offset_r + ADDRESS_BITS'(2);
          end
        end
      end
      acp_pkg::OP_OPEN: begin
        if ({1'b0, item_i.clip_id} < (ID_W+1)'(CLIP_COUNT)) begin
          offset_nxt = '0;
          active_nxt = 1'b1;
          clip_nxt   = item_i.clip_id;
        end
      end
      acp_pkg::OP_CLOSE: begin
        active_nxt = 1'b0;
      end
      acp_pkg::OP_VOL_UP: begin
        music_nxt = 1'b1;
        if (volume_r < acp_pkg::FULL_VOLUME) begin
          volume_nxt = volume_r + VOL_W'(1);
        end
      end
      acp_pkg::OP_VOL_DOWN: begin
        music_nxt = 1'b0;
        if (volume_r != '0) begin
          volume_nxt = volume_r - VOL_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Base of the clip after this word; clips without a register start at 0
  always_comb begin
    base_sel = '0;
    if ({1'b0, clip_nxt} < (ID_W+1)'(acp_pkg::NUM_BASE)) begin
      base_sel = bases_i[clip_nxt];
    end
  end

  assign addr_sum = (WIDE_W'(base_sel) + WIDE_W'(offset_nxt)) &
                    WIDE_W'({ADDRESS_BITS{1'b1}});

  // Assemble the result word
  always_comb begin
    result_o.dac_write    = dac_write;
    result_o.dac_value    = dac_write ?
        product[acp_pkg::DAC_W+acp_pkg::SCALE_SHIFT-1:acp_pkg::SCALE_SHIFT] : '0;
    result_o.playing      = active_nxt;
    result_o.read_address = addr_sum[acp_pkg::BASE_W-1:0];
    result_o.volume_level = volume_nxt;
  end

  // Commit state when the word moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      clip_r   <= '0;
      offset_r <= '0;
      volume_r <= acp_pkg::FULL_VOLUME;
      music_r  <= 1'b0;
    end else if (step_i) begin
      active_r <= active_nxt;
      clip_r   <= clip_nxt;
      offset_r <= offset_nxt;
      volume_r <= volume_nxt;
      music_r  <= music_nxt;
    end
  end

endmodule

`default_nettype wire

>>> dv/audio_clip_player_with_volume_core_test.sv
// Self-checking testbench for the audio clip player core: drives event words and APB writes.
// Predicts every status word and checks it. Depends on acp_pkg and the core RTL only.
`timescale 1ns / 1ps

module audio_clip_player_with_volume_core_test;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int QUIET_LIMIT   = 5000;
  localparam int LONG_HOLD     = 300;
  localparam int PHASE_WORDS   = 350;
  localparam int ADDR_BITS     = acp_pkg::ADDRESS_BITS_DEF;

  // Local copies of the field widths
  localparam int OP_W        = acp_pkg::OP_W;
  localparam int ID_W        = acp_pkg::ID_W;
  localparam int WORD_W      = acp_pkg::WORD_W;
  localparam int VOL_W       = acp_pkg::VOL_W;
  localparam int DAC_W       = acp_pkg::DAC_W;
  localparam int BASE_W      = acp_pkg::BASE_W;
  localparam int NUM_BASE    = acp_pkg::NUM_BASE;
  localparam int CFG_AW      = acp_pkg::CFG_AW;
  localparam int CFG_DW      = acp_pkg::CFG_DW;
  localparam int SCALE_SHIFT = acp_pkg::SCALE_SHIFT;

  // Operation codes the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_HI = 3'd7;

  // Scoreboard: shadow player state and the queue of status words still owed
  class clip_player_scoreboard;
    logic [BASE_W-1:0]    clip_base [NUM_BASE];
    bit                   playing;
    logic [ID_W-1:0]      clip;
    logic [ADDR_BITS-1:0] offset;
    logic [VOL_W-1:0]     volume;
    bit                   music_on;
    acp_pkg::acp_result_t expected_status [$];
    int                   mismatches;

    function new();
      foreach (clip_base[i]) clip_base[i] = '0;
      playing    = 1'b0;
      clip       = '0;
      offset     = '0;
      volume     = acp_pkg::FULL_VOLUME;
      music_on   = 1'b0;
      mismatches = 0;
    endfunction

    function void set_base(int idx, logic [CFG_DW-1:0] data);
      if (idx < NUM_BASE) clip_base[idx] = data[BASE_W-1:0];
    endfunction

    function int expected_count();
      return expected_status.size();
    endfunction

    // Advance the shadow state by one event word and queue its status word
    function void note_word(acp_pkg::acp_item_t w);
      acp_pkg::acp_result_t r;
      logic [20:0]          scaled;
      logic [ADDR_BITS-1:0] base;
      r = '0;
      case (w.operation)
        acp_pkg::OP_TICK: begin
          if (playing) begin
            if (w.sample_word == acp_pkg::END_WORD) begin
              // prompt with music on, or the music itself, loops the music clip
              if ((clip == acp_pkg::START_CLIP && music_on) ||
                  clip == acp_pkg::MUSIC_CLIP) begin
                clip   = acp_pkg::MUSIC_CLIP;
                offset = '0;
              end else begin
                playing = 1'b0;
              end
            end else begin
              scaled      = 21'(w.sample_word) * 21'(volume);
              r.dac_write = 1'b1;
              r.dac_value = scaled[SCALE_SHIFT +: DAC_W];
              offset      = offset + ADDR_BITS'(2);
            end
          end
        end
        acp_pkg::OP_OPEN: begin
          if (w.clip_id < acp_pkg::CLIP_COUNT_DEF) begin
            offset  = '0;
            playing = 1'b1;
            clip    = w.clip_id;
          end
        end
        acp_pkg::OP_CLOSE: begin
          playing = 1'b0;
        end
        acp_pkg::OP_VOL_UP: begin
          music_on = 1'b1;
          if (volume < acp_pkg::FULL_VOLUME) volume = volume + VOL_W'(1);
        end
        acp_pkg::OP_VOL_DOWN: begin
          music_on = 1'b0;
          if (volume != '0) volume = volume - VOL_W'(1);
        end
        default: begin
        end
      endcase
      base = (clip < NUM_BASE) ? ADDR_BITS'(clip_base[clip]) : '0;
      r.playing      = playing;
      r.read_address = BASE_W'(base + offset);
      r.volume_level = volume;
      expected_status.push_back(r);
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    // Compare one status word with the oldest one owed
    task check_result(acp_pkg::acp_result_t got);
      acp_pkg::acp_result_t want;
      if (expected_status.size() == 0) begin
        report_mismatch("status word with nothing expected");
      end else begin
        want = expected_status.pop_front();
        check_field("dac_write", 32'(got.dac_write), 32'(want.dac_write));
        check_field("dac_value", 32'(got.dac_value), 32'(want.dac_value));
        check_field("playing", 32'(got.playing), 32'(want.playing));
        check_field("read_address", 32'(got.read_address), 32'(want.read_address));
        check_field("volume_level", 32'(got.volume_level), 32'(want.volume_level));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_ready;
  logic [OP_W-1:0]   in_operation;
  logic [ID_W-1:0]   in_clip_id;
  logic [WORD_W-1:0] in_sample_word;
  logic out_valid, out_ready;
  logic              out_dac_write;
  logic [DAC_W-1:0]  out_dac_value;
  logic              out_playing;
  logic [BASE_W-1:0] out_read_address;
  logic [VOL_W-1:0]  out_volume_level;
  logic              cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata, cfg_prdata;
  logic              cfg_pready;

  clip_player_scoreboard sb;
  acp_pkg::acp_result_t seen_status;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int sent_words = 0;
  bit long_hold_request = 1'b0;
  int hold_left = 0;

  audio_clip_player_with_volume_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_clip_id(in_clip_id), .in_sample_word(in_sample_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_dac_write(out_dac_write), .out_dac_value(out_dac_value),
    .out_playing(out_playing), .out_read_address(out_read_address),
    .out_volume_level(out_volume_level),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #CLK_HALF clk = ~clk;

  // Drive the status ready: long hold on request, else random stalls
  always @(negedge clk) begin
    if (long_hold_request) begin
      hold_left = LONG_HOLD;
      long_hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // Check each accepted status word
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_status.dac_write    = out_dac_write;
      seen_status.dac_value    = out_dac_value;
      seen_status.playing      = out_playing;
      seen_status.read_address = out_read_address;
      seen_status.volume_level = out_volume_level;
      sb.check_result(seen_status);
    end
  end

  // End the run when nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable && cfg_pready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("audio_clip_player_with_volume_core: mismatch");
    $finish;
  end

  // One APB transfer: setup, access, finish on pready
  task automatic cfg_access(input bit is_write, input int idx, input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= CFG_AW'(idx * 4);
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    if (is_write) sb.set_base(idx, wdata);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write every clip base, poke the unused slots, then read the bases back
  task automatic program_bases(input logic [CFG_DW-1:0] vals [NUM_BASE]);
    logic [CFG_DW-1:0] rd;
    for (int i = 0; i < NUM_BASE; i++) cfg_access(1'b1, i, vals[i], rd);
    cfg_access(1'b1, NUM_BASE, $urandom(), rd);
    cfg_access(1'b1, NUM_BASE + 1, $urandom(), rd);
    for (int i = 0; i < NUM_BASE; i++) begin
      cfg_access(1'b0, i, '0, rd);
      sb.check_field($sformatf("clip_base_%0d readback", i), 32'(rd[BASE_W-1:0]),
                     32'(sb.clip_base[i]));
    end
  endtask

  // Offer one event word, with random idles ahead of it at the sender idle rate
  task automatic offer_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                            input logic [WORD_W-1:0] word);
    acp_pkg::acp_item_t w;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_clip_id     <= id;
    in_sample_word <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    w.operation   = op;
    w.clip_id     = id;
    w.sample_word = word;
    sb.note_word(w);
    sent_words++;
  endtask

  // Drop valid and wait until every owed status word has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_count() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic offer_volume_step();
    offer_word($urandom_range(1) ? acp_pkg::OP_VOL_UP : acp_pkg::OP_VOL_DOWN,
               ID_W'($urandom()), WORD_W'($urandom()));
  endtask

  // Random event, unknown operations and bad clip ids included
  task automatic offer_noise();
    logic [WORD_W-1:0] word;
    word = ($urandom_range(99) < 10) ? acp_pkg::END_WORD : WORD_W'($urandom());
    offer_word(OP_W'($urandom_range(OP_UNUSED_HI)), ID_W'($urandom()), word);
  endtask

  // Mostly well-formed playback: volume moves, open, a run of samples with some noise, often an end word
  task automatic play_clip();
    int pick;
    int n_ticks;
    logic [WORD_W-1:0] word;
    pick = $urandom_range(99);
    if (pick < 8) begin
      repeat (17) offer_word(acp_pkg::OP_VOL_DOWN, '0, '0);
      repeat ($urandom_range(3)) offer_word(acp_pkg::OP_VOL_UP, '0, '0);
    end else if (pick < 16) begin
      repeat (17) offer_word(acp_pkg::OP_VOL_UP, '0, '0);
    end else if (pick < 50) begin
      repeat ($urandom_range(4, 1)) offer_volume_step();
    end
    offer_word(acp_pkg::OP_OPEN, ID_W'($urandom_range(acp_pkg::CLIP_COUNT_DEF - 1)),
               WORD_W'($urandom()));
    n_ticks = $urandom_range(40, 1);
    for (int i = 0; i < n_ticks; i++) begin
      pick = $urandom_range(99);
      word = WORD_W'($urandom());
      if (pick < 4) offer_volume_step();
      else if (pick < 6) offer_noise();
      else offer_word(acp_pkg::OP_TICK, ID_W'($urandom()), word);
    end
    if ($urandom_range(99) < 70) begin
      offer_word(acp_pkg::OP_TICK, ID_W'($urandom()), acp_pkg::END_WORD);
      repeat ($urandom_range(10)) begin
        offer_word(acp_pkg::OP_TICK, ID_W'($urandom()), WORD_W'($urandom()));
      end
    end
    if ($urandom_range(99) < 30) begin
      offer_word(acp_pkg::OP_CLOSE, ID_W'($urandom()), WORD_W'($urandom()));
    end
  endtask

  // Random phase: a long receiver hold first, then mostly playback
  task automatic run_random_phase(int send_pct, int recv_pct);
    int goal;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = sent_words + PHASE_WORDS;
    long_hold_request = 1'b1;
    while (sent_words < goal) begin
      if ($urandom_range(99) < 75) play_clip();
      else repeat ($urandom_range(5, 1)) offer_noise();
    end
    wait_drained();
  endtask

  // Corner cases: idle ticks, unknown ops, bad ids, end words for each clip kind
  task automatic run_directed();
    offer_word(acp_pkg::OP_TICK, '0, 16'h1234);
    offer_word(OP_UNUSED_LO, 3'd7, acp_pkg::END_WORD);
    offer_word(OP_UNUSED_HI, '0, '0);
    offer_word(acp_pkg::OP_VOL_UP, '0, '0);
    offer_word(acp_pkg::OP_OPEN, 3'd7, '0);
    offer_word(acp_pkg::OP_OPEN, 3'd6, '0);
    offer_word(acp_pkg::OP_OPEN, acp_pkg::START_CLIP, '0);
    offer_word(acp_pkg::OP_TICK, '0, 16'hFFFE);
    offer_word(acp_pkg::OP_TICK, '0, 16'h0000);
    offer_word(acp_pkg::OP_TICK, '0, acp_pkg::END_WORD);
    offer_word(acp_pkg::OP_TICK, '0, 16'h8001);
    offer_word(acp_pkg::OP_TICK, '0, acp_pkg::END_WORD);
    offer_word(acp_pkg::OP_VOL_DOWN, '0, '0);
    offer_word(acp_pkg::OP_OPEN, acp_pkg::START_CLIP, '0);
    offer_word(acp_pkg::OP_TICK, '0, acp_pkg::END_WORD);
    offer_word(acp_pkg::OP_TICK, '0, 16'h5555);
    offer_word(acp_pkg::OP_OPEN, 3'd5, '0);
    offer_word(acp_pkg::OP_TICK, '0, 16'h7FFF);
    offer_word(acp_pkg::OP_CLOSE, '0, '0);
    offer_word(acp_pkg::OP_TICK, '0, 16'hAAAA);
    offer_word(acp_pkg::OP_OPEN, 3'd0, '0);
    offer_word(acp_pkg::OP_TICK, '0, acp_pkg::END_WORD);
    offer_word(acp_pkg::OP_OPEN, 3'd3, '0);
    offer_word(acp_pkg::OP_VOL_UP, '0, '0);
    offer_word(acp_pkg::OP_TICK, '0, acp_pkg::END_WORD);
    wait_drained();
  endtask

  initial begin
    logic [CFG_DW-1:0] bases [NUM_BASE];
    sb = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = acp_pkg::OP_TICK;
    in_clip_id     = '0;
    in_sample_word = '0;
    out_ready      = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: bases near both ends, junk in the upper data bits
    bases = '{32'h0, 32'hFFFFF0, 32'hA5123456, 32'h800000, 32'hFFFFFE, 32'hFFFFFFFF};
    program_bases(bases);
    run_directed();

    // Random bases, sender idles less than receiver
    foreach (bases[i]) bases[i] = $urandom();
    program_bases(bases);
    run_random_phase(30, 47);

    // All bases at the top, idling swapped
    foreach (bases[i]) bases[i] = '1;
    program_bases(bases);
    run_random_phase(47, 30);

    // All bases at zero, no idling
    foreach (bases[i]) bases[i] = '0;
    program_bases(bases);
    run_random_phase(0, 0);

    if (sb.mismatches == 0) begin
      $display("audio_clip_player_with_volume_core: match");
    end else begin
      $display("audio_clip_player_with_volume_core: mismatch");
    end
    $finish;
  end

endmodule
